// ===== design/assert_macros.svh =====
// Assertion macros shared by the envelope generator modules.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true at a clock edge
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== design/adsr_pkg.sv =====
// Shared types and constants for the linear ADSR envelope generator.
// No dependencies; imported by every module of the block.
package adsr_pkg;

    // Fixed field widths
    localparam int LEN_W    = 20;   // ramp length registers
    localparam int SUS_W    = 16;   // sustain fraction, Q0.16
    localparam int AMP_W    = 16;   // amplitude and emitted level
    localparam int PHASE_W  = 3;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    // Register indexes on the APB port (paddr[3:2])
    localparam logic [1:0] REG_ATTACK  = 2'd0;
    localparam logic [1:0] REG_DECAY   = 2'd1;
    localparam logic [1:0] REG_SUSTAIN = 2'd2;
    localparam logic [1:0] REG_RELEASE = 2'd3;

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_NOTE_ON  = 2'd1,
        CMD_NOTE_OFF = 2'd2
    } cmd_t;

    typedef enum logic [PHASE_W-1:0] {
        PH_ATTACK  = 3'd0,
        PH_DECAY   = 3'd1,
        PH_SUSTAIN = 3'd2,
        PH_RELEASE = 3'd3,
        PH_DONE    = 3'd4
    } phase_t;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_DIVIDE = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic [1:0]       command;
        logic [AMP_W-1:0] amplitude;
    } in_item_t;

    typedef struct packed {
        logic [AMP_W-1:0]   level;
        logic [PHASE_W-1:0] phase;
    } out_item_t;

    typedef struct packed {
        logic [LEN_W-1:0] attack_samples;
        logic [LEN_W-1:0] decay_samples;
        logic [SUS_W-1:0] sustain_level;
        logic [LEN_W-1:0] release_samples;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic note_on;
        logic note_off;
        logic tick;
        logic div_start;
        logic load_step;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic active;       // phase is not done
        logic attack_end;   // this tick's step reaches the peak
    } dp_stat_t;

endpackage

// ===== design/adsr_div.sv =====
// Restoring divider, one quotient bit per cycle, result rounded up.
// Depends on adsr_pkg and assert_macros.svh.
module adsr_div
    import adsr_pkg::*;
#(
    parameter int NUM_W = 33
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [LEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    `include "assert_macros.svh"

    localparam int CNT_W = $clog2(NUM_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [LEN_W-1:0] rem_reg;
    logic [LEN_W-1:0] den_reg;

    logic [LEN_W:0]   shifted;
    logic [LEN_W:0]   trial;
    logic             q_bit;
    logic [LEN_W-1:0] rem_next;

    // One restoring step
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[NUM_W-1]};
        trial    = shifted - {1'b0, den_reg};
        q_bit    = ~trial[LEN_W];
        rem_next = q_bit ? trial[LEN_W-1:0] : shifted[LEN_W-1:0];
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    // Operand and partial result registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NUM_W-2:0], q_bit};
            rem_reg <= rem_next;
        end
    end

    // Round up when a remainder is left
    assign done     = done_reg;
    assign quotient = quo_reg + NUM_W'(rem_reg != '0);

    `ASSERT_NEVER(a_start_while_busy, start && busy_reg, "divider restarted while busy")
    `ASSERT_CLK(a_done_single, done_reg |=> !done_reg, "divider done held longer than a cycle")
    `ASSERT_CLK(a_last_step_done, (busy_reg && !start && cnt_reg == CNT_LAST) |=> (done_reg && !busy_reg), "divider did not finish after last step")

endmodule

// ===== design/adsr_ctrl.sv =====
// Controller: handshakes, output valid and the wait on the divider.
// Depends on adsr_pkg and assert_macros.svh.
module adsr_ctrl
    import adsr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_cmd,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  dp_stat_t   stat,
    input  logic       div_done,
    output dp_cmd_t    cmd
);

    `include "assert_macros.svh"

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_full;
    logic        accept;

    assign out_full = out_valid_reg && out_stall;

    // Outputs and datapath commands
    always_comb
    begin
        cmd    = '0;
        accept = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                accept = in_valid && !out_full;
            end
            ST_DIVIDE:
            begin
                cmd.load_step = div_done;
            end
            default:
            begin
                accept = 1'b0;
            end
        endcase

        if (accept)
        begin
            case (in_cmd)
                CMD_TICK:     cmd.tick     = 1'b1;
                CMD_NOTE_ON:  cmd.note_on  = 1'b1;
                CMD_NOTE_OFF: cmd.note_off = stat.active;
                default:      cmd.tick     = 1'b0;
            endcase
        end
        cmd.div_start = cmd.note_on || cmd.note_off || (cmd.tick && stat.attack_end);

        in_stall = (state_reg != ST_IDLE) || out_full;
        out_valid_next = cmd.tick ? 1'b1 : (out_valid_reg && out_stall);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.div_start)
                    state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (div_done)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `ASSERT_NEVER(a_done_outside_divide, div_done && state_reg != ST_DIVIDE, "divider finished while controller idle")
    `ASSERT_NEVER(a_tick_into_full, cmd.tick && out_full, "tick result loaded over a waiting result")
    `ASSERT_CLK(a_start_enters_divide, cmd.div_start |=> state_reg == ST_DIVIDE, "divide start did not enter wait state")

endmodule

// ===== design/adsr_dp.sv =====
// Datapath: level, step, peak and phase registers, ramp arithmetic,
// divider operand selection and the output register. Depends on adsr_pkg.
module adsr_dp
    import adsr_pkg::*;
#(
    parameter int FRAC_BITS   = 16,
    parameter int SAMPLE_BITS = 16,
    parameter int LVL_W       = 33
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  dp_cmd_t          cmd,
    input  logic [AMP_W-1:0] amplitude,
    input  cfg_t             cfg,
    output dp_stat_t         stat,
    output logic [LVL_W-1:0] div_num,
    output logic [LEN_W-1:0] div_den,
    input  logic [LVL_W-1:0] div_quotient,
    output out_item_t        out_data
);

    localparam int PROD_W = 2 * AMP_W + FRAC_BITS;
    localparam logic [31:0] SAT_VAL = (32'd1 << SAMPLE_BITS) - 32'd1;

    phase_t           phase_reg;
    phase_t           phase_next;
    logic [LVL_W-1:0] level_reg;
    logic [LVL_W-1:0] level_next;
    logic [LVL_W-1:0] step_reg;
    logic [LVL_W-1:0] step_next;
    logic [AMP_W-1:0] peak_reg;
    logic [AMP_W-1:0] peak_next;
    out_item_t        out_data_reg;
    out_item_t        out_next;

    logic [LVL_W-1:0]           peak_fixed;
    logic [2*AMP_W-1:0]         prod;
    logic [PROD_W-1:0]          prod_wide;
    logic [LVL_W-1:0]           target;
    logic [LVL_W-1:0]           sum;
    logic [LVL_W:0]             diff;
    logic [LVL_W-1:0]           fall_level;
    logic                       attack_end;
    logic                       release_end;
    logic [31:0]                sample_w;

    // Ramp arithmetic
    always_comb
    begin
        peak_fixed  = LVL_W'(peak_reg) << FRAC_BITS;
        prod        = peak_reg * cfg.sustain_level;
        prod_wide   = PROD_W'(prod) << FRAC_BITS;
        target      = LVL_W'(prod_wide >> SUS_W);
        sum         = level_reg + step_reg;
        diff        = {1'b0, level_reg} - {1'b0, step_reg};
        fall_level  = diff[LVL_W] ? '0 : diff[LVL_W-1:0];
        attack_end  = (phase_reg == PH_ATTACK) && (sum >= peak_fixed);
        release_end = diff[LVL_W] || (diff[LVL_W-1:0] == '0);
    end

    assign stat.active     = (phase_reg != PH_DONE);
    assign stat.attack_end = attack_end;

    // Divider operands; a zero length counts as one
    always_comb
    begin
        if (cmd.note_on)
        begin
            div_num = LVL_W'(amplitude) << FRAC_BITS;
            div_den = (cfg.attack_samples == '0) ? LEN_W'(1) : cfg.attack_samples;
        end
        else if (cmd.note_off)
        begin
            div_num = level_reg;
            div_den = (cfg.release_samples == '0) ? LEN_W'(1) : cfg.release_samples;
        end
        else
        begin
            div_num = peak_fixed - target;
            div_den = (cfg.decay_samples == '0) ? LEN_W'(1) : cfg.decay_samples;
        end
    end

    // Emitted sample: level before the step, saturated, zero when done
    always_comb
    begin
        sample_w = 32'(level_reg[LVL_W-1:FRAC_BITS]);
        if (sample_w > SAT_VAL)
            sample_w = SAT_VAL;
        out_next.level = (phase_reg == PH_DONE) ? '0 : sample_w[AMP_W-1:0];
        out_next.phase = phase_reg;
    end

    // State update
    always_comb
    begin
        phase_next = phase_reg;
        level_next = level_reg;
        step_next  = step_reg;
        peak_next  = peak_reg;
        if (cmd.note_on)
        begin
            peak_next  = amplitude;
            phase_next = PH_ATTACK;
            level_next = '0;
        end
        else if (cmd.note_off)
        begin
            phase_next = PH_RELEASE;
        end
        else if (cmd.tick)
        begin
            case (phase_reg)
                PH_ATTACK:
                begin
                    level_next = sum;
                    if (attack_end)
                        phase_next = PH_DECAY;
                end
                PH_DECAY:
                begin
                    level_next = fall_level;
                    if (fall_level <= target)
                    begin
                        phase_next = PH_SUSTAIN;
                        step_next  = '0;
                    end
                end
                PH_RELEASE:
                begin
                    if (release_end)
                    begin
                        level_next = '0;
                        step_next  = '0;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        level_next = diff[LVL_W-1:0];
                    end
                end
                default:
                begin
                    level_next = level_reg;
                end
            endcase
        end
        if (cmd.load_step)
            step_next = div_quotient;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_DONE;
            level_reg <= '0;
            step_reg  <= '0;
            peak_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            level_reg <= level_next;
            step_reg  <= step_next;
            peak_reg  <= peak_next;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.tick)
            out_data_reg <= out_next;
    end

    assign out_data = out_data_reg;

endmodule

// ===== design/adsr_envelope_generator.sv =====
// Top level of the linear ADSR envelope generator: APB register file,
// controller, datapath and divider. Depends on adsr_pkg and the adsr_* modules.
//
//  channel   direction  handshake              payload
//  in        input      in_valid / in_stall    in_data  (in_item_t)
//  out       output     out_valid / out_stall  out_data (out_item_t)
//  apb       input      psel/penable/pwrite    paddr, pwdata, prdata
//
// A tick's sample is registered for the output side.
// Note on, note off (unless done) and the tick that ends attack run the
// shared divider, one quotient bit a cycle, and the input stalls until
// the divider is done.
// The input also stalls while a result is held by out_stall.
// Reset leaves the envelope done with level, step and peak at zero.
module adsr_envelope_generator
    import adsr_pkg::*;
#(
    parameter int FRAC_BITS   = 16,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_item_t          in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output out_item_t         out_data
);

    localparam int LVL_W = AMP_W + 1 + FRAC_BITS;

    cfg_t             cfg_reg;
    logic [1:0]       reg_index;
    dp_cmd_t          cmd;
    dp_stat_t         stat;
    logic [LVL_W-1:0] div_num;
    logic [LEN_W-1:0] div_den;
    logic [LVL_W-1:0] div_quotient;
    logic             div_done;

    assign reg_index = paddr[3:2];
    assign pready    = 1'b1;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attack_samples  <= LEN_W'(80);
            cfg_reg.decay_samples   <= LEN_W'(80);
            cfg_reg.sustain_level   <= SUS_W'(32768);
            cfg_reg.release_samples <= LEN_W'(80);
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_index)
                REG_ATTACK:  cfg_reg.attack_samples  <= pwdata[LEN_W-1:0];
                REG_DECAY:   cfg_reg.decay_samples   <= pwdata[LEN_W-1:0];
                REG_SUSTAIN: cfg_reg.sustain_level   <= pwdata[SUS_W-1:0];
                REG_RELEASE: cfg_reg.release_samples <= pwdata[LEN_W-1:0];
                default:     cfg_reg.attack_samples  <= cfg_reg.attack_samples;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        case (reg_index)
            REG_ATTACK:  prdata = DATA_W'(cfg_reg.attack_samples);
            REG_DECAY:   prdata = DATA_W'(cfg_reg.decay_samples);
            REG_SUSTAIN: prdata = DATA_W'(cfg_reg.sustain_level);
            REG_RELEASE: prdata = DATA_W'(cfg_reg.release_samples);
            default:     prdata = '0;
        endcase
    end

    adsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_cmd    (in_data.command),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .div_done  (div_done),
        .cmd       (cmd)
    );

    adsr_dp #(
        .FRAC_BITS   (FRAC_BITS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .LVL_W       (LVL_W)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .amplitude    (in_data.amplitude),
        .cfg          (cfg_reg),
        .stat         (stat),
        .div_num      (div_num),
        .div_den      (div_den),
        .div_quotient (div_quotient),
        .out_data     (out_data)
    );

    adsr_div #(
        .NUM_W (LVL_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .num      (div_num),
        .den      (div_den),
        .done     (div_done),
        .quotient (div_quotient)
    );

endmodule
